// File: rtl/rqsc_pkg.sv
// ----------------------------------------------------------------------------
// rqsc_pkg
// types and constants for the request queue with select and cancel
// ----------------------------------------------------------------------------
package rqsc_pkg;

  localparam int SlotsDefault = 64;
  localparam int BatchDefault = 32;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_CANCEL = 2'd1,
    OP_SELECT = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_ORDER    = 2'd0,
    MODE_OLDEST   = 2'd1,
    MODE_PRIORITY = 2'd2,
    MODE_SPARE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_SELECTED  = 3'd4,
    ST_NONE      = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] req_id;
    logic [31:0] arrival_stamp;
    logic [7:0]  priority_req;
    logic [5:0]  select_count;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_id;
    logic [31:0] out_arrival;
    logic [7:0]  out_priority;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] arrival;
    logic [7:0]  prio;
  } entry_t;

endpackage

// File: rtl/rqsc_store.sv
// ----------------------------------------------------------------------------
// rqsc_store
// entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module rqsc_store #(
  parameter int DEPTH = rqsc_pkg::SlotsDefault,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  rqsc_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output rqsc_pkg::entry_t rdata
);
  import rqsc_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/request_queue_select_cancel.sv
// ----------------------------------------------------------------------------
// request_queue_select_cancel
// ordered request queue: submit, cancel by id, select by mode
// ----------------------------------------------------------------------------
// channel   dir  handshake             payload
// cmd       in   cmd_valid/cmd_ready   req_t
// rsp       out  rsp_valid/rsp_ready   rsp_t
// cfg       in   cfg_we                select_mode
// submit: writes the entry at the tail. cancel: reads and checks entries in
// queue order until the id matches, then moves each later entry down one slot.
// select: in queue order (also the spare mode) takes the head entry per result;
// in oldest and priority order scans every entry per result, then moves each
// later entry over the chosen one; scans and moves share the single memory read
// port. a waiting response holds the sequencer and the input. no clearing pass after reset.
// ----------------------------------------------------------------------------
module request_queue_select_cancel #(
  parameter int DEPTH       = rqsc_pkg::SlotsDefault,
  parameter int BATCH_LIMIT = rqsc_pkg::BatchDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  rqsc_pkg::req_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output rqsc_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_wdata
);
  import rqsc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int BW = $clog2(BATCH_LIMIT + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SUB, S_CSCAN, S_CCHK, S_SSCAN, S_SCHK, S_SEMIT,
    S_MRD, S_MWR, S_RESP
  } state_t;

  state_t         state;
  mode_t          mode;
  req_t           req;
  logic [AW-1:0]  head;
  logic [CW-1:0]  occ;
  logic [CW-1:0]  pos;      // position of current read
  logic [CW-1:0]  best;
  entry_t         best_e;
  logic [CW-1:0]  mpos;     // compaction position
  logic [BW-1:0]  want;
  logic [BW-1:0]  done_n;
  logic           cancel_op;
  rsp_t           rsp_reg;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  entry_t         wdata, rdata;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, h} + {1'b0, p};
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  rqsc_store #(.DEPTH(DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // combinational memory port control
  always_comb begin
    we    = 1'b0;
    waddr = slot(head, occ);
    wdata = '{id: req.req_id, arrival: req.arrival_stamp, prio: req.priority_req};
    raddr = slot(head, pos);
    unique case (state)
      S_SUB: we = 1'b1;
      S_MRD: raddr = slot(head, mpos + CW'(1));
      S_MWR: begin
        we    = 1'b1;
        waddr = slot(head, mpos);
        wdata = rdata;
        raddr = slot(head, mpos + CW'(1));
      end
      default: ;
    endcase
  end

  logic better;
  always_comb begin
    case (mode)
      MODE_OLDEST:   better = rdata.arrival < best_e.arrival;
      MODE_PRIORITY: better = rdata.prio > best_e.prio;
      default:       better = 1'b0;
    endcase
  end

  assign cmd_ready = (state == S_IDLE) && !rsp_valid;
  assign rsp       = rsp_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= MODE_ORDER;
      head      <= '0;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode <= mode_t'(cfg_wdata);
      end
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            req    <= cmd;
            pos    <= '0;
            done_n <= '0;
            want   <= (int'(cmd.select_count) > BATCH_LIMIT) ? BW'(BATCH_LIMIT)
                                                            : BW'(cmd.select_count);
            rsp_reg.out_id       <= cmd.req_id;
            rsp_reg.out_arrival  <= '0;
            rsp_reg.out_priority <= '0;
            rsp_reg.last         <= 1'b1;
            unique case (opcode_t'(cmd.opcode))
              OP_SUBMIT: begin
                if (occ >= CW'(DEPTH)) begin
                  rsp_reg.status <= ST_FULL;
                  state          <= S_RESP;
                end else begin
                  rsp_reg.status <= ST_ACCEPTED;
                  state          <= S_SUB;
                end
              end
              OP_CANCEL: begin
                cancel_op <= 1'b1;
                if (occ == '0) begin
                  rsp_reg.status <= ST_NOT_FOUND;
                  state          <= S_RESP;
                end else begin
                  state <= S_CSCAN;
                end
              end
              OP_SELECT: begin
                cancel_op <= 1'b0;
                if (occ == '0 || cmd.select_count == '0) begin
                  rsp_reg.status <= ST_NONE;
                  rsp_reg.out_id <= '0;
                  state          <= S_RESP;
                end else begin
                  state <= S_SSCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SUB: begin
          occ   <= occ + CW'(1);
          state <= S_RESP;
        end
        S_CSCAN: state <= S_CCHK;
        S_CCHK: begin
          if (rdata.id == req.req_id) begin
            rsp_reg.status <= ST_CANCELLED;
            mpos           <= pos;
            state          <= S_MRD;
          end else if (pos + CW'(1) >= occ) begin
            rsp_reg.status <= ST_NOT_FOUND;
            state          <= S_RESP;
          end else begin
            pos   <= pos + CW'(1);
            state <= S_CSCAN;
          end
        end
        S_SSCAN: state <= S_SCHK;
        S_SCHK: begin
          if (pos == '0 || better) begin
            best   <= pos;
            best_e <= rdata;
          end
          if (pos + CW'(1) >= occ || mode == MODE_ORDER || mode == MODE_SPARE) begin
            state <= S_SEMIT;
          end else begin
            pos   <= pos + CW'(1);
            state <= S_SSCAN;
          end
        end
        S_SEMIT: begin
          if (!rsp_valid) begin
            rsp_reg.status       <= ST_SELECTED;
            rsp_reg.out_id       <= best_e.id;
            rsp_reg.out_arrival  <= best_e.arrival;
            rsp_reg.out_priority <= best_e.prio;
            rsp_reg.last <= (done_n + BW'(1) == want) || (occ == CW'(1));
            rsp_valid    <= 1'b1;
            done_n       <= done_n + BW'(1);
            if (mode == MODE_OLDEST || mode == MODE_PRIORITY) begin
              mpos  <= best;
              state <= S_MRD;
            end else begin
              head  <= slot(head, CW'(1));
              occ   <= occ - CW'(1);
              pos   <= '0;
              state <= (done_n + BW'(1) == want || occ == CW'(1)) ? S_IDLE : S_SSCAN;
            end
          end
        end
        S_MRD: begin
          if (mpos + CW'(1) >= occ) begin
            occ <= occ - CW'(1);
            pos <= '0;
            if (cancel_op) begin
              state <= S_RESP;
            end else begin
              state <= (done_n == want || occ == CW'(1)) ? S_IDLE : S_SSCAN;
            end
          end else begin
            state <= S_MWR;
          end
        end
        S_MWR: begin
          mpos  <= mpos + CW'(1);
          state <= S_MRD;
        end
        S_RESP: begin
          if (!rsp_valid) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(DEPTH)) else $error("occupancy above depth");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd.opcode != OP_NONE) |=> !cmd_ready)
    else $error("ready during work");
  a_sel_status: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) && rsp.status == ST_SELECTED |-> $past(occ) != '0)
    else $error("selected from empty queue");

endmodule

// File: test/request_queue_select_cancel_tb.sv
// ----------------------------------------------------------------------------
// request_queue_select_cancel_tb
// self-checking bench: submit, cancel and select transactions are predicted
// by a behavioral queue model and compared with each response in order,
// across all select modes, with random idling and backpressure
// ----------------------------------------------------------------------------
module request_queue_select_cancel_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rqsc_pkg::*;

  localparam int Depth = 64;
  localparam int Batch = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  req_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;

  request_queue_select_cancel dut (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  entry_t held[$];
  mode_t cur_mode = MODE_ORDER;
  rsp_t expected_rsp[$];
  req_t pending_cmd[$];
  int errors = 0;
  event hold_go;
  bit hold_active = 1'b0;
  bit cmd_taken = 1'b0;
  bit idle_on = 1'b1;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic rsp_t mk(status_t st, logic [31:0] id, logic [31:0] arr,
                              logic [7:0] pr, logic lst);
    rsp_t r;
    r.status = st;
    r.out_id = id;
    r.out_arrival = arr;
    r.out_priority = pr;
    r.last = lst;
    return r;
  endfunction

  task automatic predict_queue(input req_t c);
    int want;
    int n;
    int best;
    entry_t e;
    bit hit;
    n = 0;
    hit = 1'b0;
    case (opcode_t'(c.opcode))
      OP_SUBMIT: begin
        if (held.size() >= Depth) begin
          expected_rsp.push_back(mk(ST_FULL, c.req_id, '0, '0, 1'b1));
        end else begin
          e.id = c.req_id;
          e.arrival = c.arrival_stamp;
          e.prio = c.priority_req;
          held.push_back(e);
          expected_rsp.push_back(mk(ST_ACCEPTED, c.req_id, '0, '0, 1'b1));
        end
      end
      OP_CANCEL: begin
        for (int p = 0; p < held.size(); p++) begin
          if (!hit && held[p].id == c.req_id) begin
            held.delete(p);
            hit = 1'b1;
          end
        end
        expected_rsp.push_back(mk(hit ? ST_CANCELLED : ST_NOT_FOUND, c.req_id,
                                  '0, '0, 1'b1));
      end
      OP_SELECT: begin
        want = (int'(c.select_count) > Batch) ? Batch : int'(c.select_count);
        while (n < want && held.size() > 0) begin
          best = 0;
          for (int p = 1; p < held.size(); p++) begin
            if (cur_mode == MODE_OLDEST && held[p].arrival < held[best].arrival) best = p;
            if (cur_mode == MODE_PRIORITY && held[p].prio > held[best].prio) best = p;
          end
          expected_rsp.push_back(mk(ST_SELECTED, held[best].id, held[best].arrival,
                                    held[best].prio, 1'b0));
          held.delete(best);
          n++;
        end
        if (n == 0) expected_rsp.push_back(mk(ST_NONE, '0, '0, '0, 1'b1));
        else expected_rsp[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // long receiver hold-off
  always begin
    @(hold_go);
    hold_active = 1'b1;
    repeat (3000) @(posedge clk);
    hold_active = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_taken) begin
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        cmd_valid <= 1'b0;
      end else if (pending_cmd.size() > 0) begin
        cmd <= pending_cmd.pop_front();
        cmd_valid <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 5);
      end else begin
        cmd_valid <= 1'b0;
      end
      if (hold_active) begin
        rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    cmd_taken = cmd_valid && cmd_ready;
    if (!rst && cmd_valid && cmd_ready) predict_queue(cmd);
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("%0t unexpected response: actual %p", $time, rsp);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status || rsp.out_id !== want.out_id ||
            rsp.out_arrival !== want.out_arrival ||
            rsp.out_priority !== want.out_priority || rsp.last !== want.last) begin
          errors++;
          $display("%0t mismatch: expected %p actual %p", $time, want, rsp);
        end
      end
    end
  end

  function automatic req_t op_item(opcode_t op, logic [31:0] id, logic [31:0] arr,
                                   logic [31:0] pr, logic [31:0] cnt);
    req_t c;
    c.opcode = op;
    c.req_id = id;
    c.arrival_stamp = arr;
    c.priority_req = pr[7:0];
    c.select_count = cnt[5:0];
    return c;
  endfunction

  task automatic drain_all();
    while (pending_cmd.size() > 0 || cmd_valid || expected_rsp.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_mode(mode_t m);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_mode = m;
  endtask

  task automatic random_phase(int count);
    req_t c;
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 19);
      if (k < 10)
        c = op_item(OP_SUBMIT, $urandom_range(0, 40), $urandom,
                    $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom, $urandom);
      else if (k < 14)
        c = op_item(OP_CANCEL, $urandom_range(0, 40), $urandom, $urandom, $urandom);
      else if (k < 19)
        c = op_item(OP_SELECT, $urandom, $urandom, $urandom,
                    $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4));
      else
        c = op_item(OP_NONE, $urandom, $urandom, $urandom, $urandom);
      pending_cmd.push_back(c);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every opcode and special case
    pending_cmd.push_back(op_item(OP_SELECT, '0, '0, '0, 5));
    pending_cmd.push_back(op_item(OP_CANCEL, 32'hFFFF_FFFF, '0, '0, '0));
    pending_cmd.push_back(op_item(OP_SUBMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFF, 63));
    pending_cmd.push_back(op_item(OP_SUBMIT, '0, '0, '0, '0));
    pending_cmd.push_back(op_item(OP_SUBMIT, 32'd7, 32'd0, 32'hFF, '0));
    pending_cmd.push_back(op_item(OP_NONE, 32'd7, '1, '1, '1));
    pending_cmd.push_back(op_item(OP_SELECT, '0, '0, '0, '0));
    pending_cmd.push_back(op_item(OP_CANCEL, 32'd0, '0, '0, '0));
    pending_cmd.push_back(op_item(OP_CANCEL, 32'd0, '0, '0, '0));
    pending_cmd.push_back(op_item(OP_SELECT, '0, '0, '0, 63));
    drain_all();

    // fill past capacity, select in batches
    for (int i = 0; i < Depth + 2; i++)
      pending_cmd.push_back(op_item(OP_SUBMIT, i, $urandom, $urandom, '0));
    pending_cmd.push_back(op_item(OP_SELECT, '0, '0, '0, 33));
    pending_cmd.push_back(op_item(OP_SELECT, '0, '0, '0, 40));
    drain_all();

    // long receiver hold-off while the sender keeps offering
    -> hold_go;
    random_phase(60);
    drain_all();

    write_mode(MODE_OLDEST);
    random_phase(90);
    drain_all();
    write_mode(MODE_PRIORITY);
    random_phase(90);
    drain_all();
    write_mode(MODE_SPARE);
    random_phase(60);
    drain_all();
    write_mode(MODE_ORDER);
    random_phase(50);
    drain_all();
    write_mode(MODE_PRIORITY);
    idle_on = 1'b0;
    random_phase(40);
    pending_cmd.push_back(op_item(OP_SELECT, '0, '0, '0, 63));
    pending_cmd.push_back(op_item(OP_SELECT, '0, '0, '0, 63));
    drain_all();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
